### rtl/core/xsks_pkg.sv
// Shared types, constants and generator functions for the xorshift keystream byte scrambler.
// Used by xsks_engine, xsks_emit and the top level; depends on nothing else.
`timescale 1ns / 1ps

package xsks_pkg;

    localparam logic [4:0]  HDR_LEN       = 5'd16;
    localparam logic [4:0]  HDR_HALF      = 5'd8;
    localparam logic [3:0]  KEY_IDX_EMPTY = 4'd8;
    localparam logic [63:0] ZERO_SEED_A   = 64'h9e3779b97f4a7c15;
    localparam logic [63:0] ZERO_SEED_B   = 64'hbf58476d1ce4e5b9;

    typedef enum logic [1:0] {
        CFG_MODE        = 2'd0,
        CFG_SEED_FIRST  = 2'd1,
        CFG_SEED_SECOND = 2'd2
    } cfg_index_t;

    localparam logic MODE_SCRAMBLE   = 1'b0;
    localparam logic MODE_UNSCRAMBLE = 1'b1;

    // One queued result: optional 16-byte header ahead of a data byte.
    typedef struct packed {
        logic       hdr;
        logic [7:0] data;
        logic       last;
    } xsks_item_t;

    typedef struct packed {
        logic       valid;
        xsks_item_t item;
    } xsks_push_t;

    typedef struct packed {
        logic [63:0] a;
        logic [63:0] b;
        logic [63:0] key;
    } xsks_gen_t;

    // A zero seed is replaced by a fixed nonzero word.
    function automatic logic [63:0] xsks_fix_seed(input logic [63:0] seed,
                                                  input logic [63:0] alt);
        return (seed == 64'd0) ? alt : seed;
    endfunction

    // One xorshift128+ step: shifts and XORs, then one 64-bit add.
    function automatic xsks_gen_t xsks_gen_step(input logic [63:0] a,
                                                input logic [63:0] b);
        xsks_gen_t   r;
        logic [63:0] x;
        x     = a ^ (a << 23);
        r.a   = b;
        r.b   = x ^ b ^ (x >> 17) ^ (b >> 26);
        r.key = r.b + b;
        return r;
    endfunction

endpackage

### rtl/core/xsks_engine.sv
// Configuration registers, generator state and per-byte keystream logic.
// Depends on xsks_pkg.
`timescale 1ns / 1ps

module xsks_engine
    import xsks_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    input  logic        fire,
    input  logic [7:0]  in_byte,
    input  logic        in_last,
    output xsks_push_t  push,
    output logic [63:0] seed_first,
    output logic [63:0] seed_second
);

    logic        mode_reg;
    logic [63:0] seed_first_reg, seed_second_reg;
    logic [63:0] gen_a_reg, gen_a_next;
    logic [63:0] gen_b_reg, gen_b_next;
    logic [63:0] key_word_reg, key_word_next;
    logic [3:0]  key_idx_reg, key_idx_next;
    logic [4:0]  hdr_cnt_reg, hdr_cnt_next;
    logic [63:0] gather_reg, gather_next;

    xsks_push_t  push_c;
    xsks_gen_t   step;
    logic        need_key;
    logic [63:0] gather_shift;
    logic [63:0] kw_sel;
    logic [2:0]  idx_sel;
    logic [7:0]  key_byte;

    always_comb
    begin
        gen_a_next    = gen_a_reg;
        gen_b_next    = gen_b_reg;
        key_word_next = key_word_reg;
        key_idx_next  = key_idx_reg;
        hdr_cnt_next  = hdr_cnt_reg;
        gather_next   = gather_reg;
        push_c        = '0;
        need_key      = 1'b0;
        gather_shift  = {in_byte, gather_reg[63:8]};

        if (mode_reg == MODE_SCRAMBLE)
        begin
            // Any header count other than the data phase marks a message start.
            if (hdr_cnt_reg != HDR_LEN)
            begin
                gen_a_next      = xsks_fix_seed(seed_first_reg, ZERO_SEED_A);
                gen_b_next      = xsks_fix_seed(seed_second_reg, ZERO_SEED_B);
                key_idx_next    = KEY_IDX_EMPTY;
                push_c.item.hdr = 1'b1;
            end
            hdr_cnt_next = HDR_LEN;
            need_key     = 1'b1;
        end
        else if (hdr_cnt_reg < HDR_LEN)
        begin
            hdr_cnt_next = hdr_cnt_reg + 5'd1;
            gather_next  = gather_shift;
            if (hdr_cnt_next == HDR_HALF)
            begin
                gen_a_next  = xsks_fix_seed(gather_shift, ZERO_SEED_A);
                gather_next = '0;
            end
            else if (hdr_cnt_next == HDR_LEN)
            begin
                gen_b_next   = xsks_fix_seed(gather_shift, ZERO_SEED_B);
                gather_next  = '0;
                key_idx_next = KEY_IDX_EMPTY;
            end
        end
        else
        begin
            need_key = 1'b1;
        end

        step    = xsks_gen_step(gen_a_next, gen_b_next);
        kw_sel  = key_idx_next[3] ? step.key : key_word_next;
        idx_sel = key_idx_next[3] ? 3'd0 : key_idx_next[2:0];
        key_byte = kw_sel[{idx_sel, 3'b000} +: 8];

        if (need_key)
        begin
            if (key_idx_next[3])
            begin
                gen_a_next    = step.a;
                gen_b_next    = step.b;
                key_word_next = step.key;
            end
            key_idx_next     = {1'b0, idx_sel} + 4'd1;
            push_c.valid     = 1'b1;
            push_c.item.data = in_byte ^ key_byte;
            push_c.item.last = in_last;
        end

        if (in_last)
        begin
            hdr_cnt_next = '0;
            gather_next  = '0;
            key_idx_next = KEY_IDX_EMPTY;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg        <= MODE_SCRAMBLE;
            seed_first_reg  <= '0;
            seed_second_reg <= '0;
            gen_a_reg       <= '0;
            gen_b_reg       <= '0;
            key_word_reg    <= '0;
            key_idx_reg     <= KEY_IDX_EMPTY;
            hdr_cnt_reg     <= '0;
            gather_reg      <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_MODE:        mode_reg        <= cfg_wdata[0];
                    CFG_SEED_FIRST:  seed_first_reg  <= cfg_wdata;
                    CFG_SEED_SECOND: seed_second_reg <= cfg_wdata;
                    default:         ;
                endcase
            end
            if (fire)
            begin
                gen_a_reg    <= gen_a_next;
                gen_b_reg    <= gen_b_next;
                key_word_reg <= key_word_next;
                key_idx_reg  <= key_idx_next;
                hdr_cnt_reg  <= hdr_cnt_next;
                gather_reg   <= gather_next;
            end
        end
    end

    always_comb
    begin
        push       = push_c;
        push.valid = push_c.valid & fire;
    end

    assign seed_first  = seed_first_reg;
    assign seed_second = seed_second_reg;

endmodule

### rtl/core/xsks_emit.sv
// Two-entry result queue and output serializer that expands header results into 16 seed bytes.
// Depends on xsks_pkg.
`timescale 1ns / 1ps

module xsks_emit
    import xsks_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  xsks_push_t  push,
    input  logic [63:0] seed_first,
    input  logic [63:0] seed_second,
    output logic        has_room,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [7:0]  out_byte,
    output logic        out_last
);

    xsks_item_t  ent_reg [2];
    logic        wr_ptr_reg, rd_ptr_reg;
    logic [1:0]  count_reg;
    logic [4:0]  hdr_cnt_reg;

    xsks_item_t  head;
    logic        in_hdr;
    logic [63:0] seed_sel;
    logic        xfer;
    logic        pop;

    assign head      = ent_reg[rd_ptr_reg];
    assign out_valid = (count_reg != 2'd0);
    assign has_room  = (count_reg != 2'd2);
    assign in_hdr    = head.hdr && (hdr_cnt_reg != HDR_LEN);
    assign seed_sel  = hdr_cnt_reg[3] ? seed_second : seed_first;
    assign out_byte  = in_hdr ? seed_sel[{hdr_cnt_reg[2:0], 3'b000} +: 8] : head.data;
    assign out_last  = in_hdr ? 1'b0 : head.last;
    assign xfer      = out_valid && out_ready;
    assign pop       = xfer && !in_hdr;

    always_ff @(posedge clk)
    begin
        if (push.valid)
        begin
            ent_reg[wr_ptr_reg] <= push.item;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg  <= 1'b0;
            rd_ptr_reg  <= 1'b0;
            count_reg   <= '0;
            hdr_cnt_reg <= '0;
        end
        else
        begin
            if (push.valid)
            begin
                wr_ptr_reg <= ~wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg  <= ~rd_ptr_reg;
                hdr_cnt_reg <= '0;
            end
            else if (xfer)
            begin
                hdr_cnt_reg <= hdr_cnt_reg + 5'd1;
            end
            if (push.valid && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push.valid)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

`ifndef SYNTHESIS
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= 2'd2)
        else $error("result queue count out of range");

    a_hdr_bound: assert property (@(posedge clk) disable iff (!rst_n)
        hdr_cnt_reg <= HDR_LEN)
        else $error("header byte counter out of range");

    a_hdr_owner: assert property (@(posedge clk) disable iff (!rst_n)
        (hdr_cnt_reg != 5'd0) |-> (out_valid && head.hdr))
        else $error("header counter running without a header entry at the head");

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push.valid |-> (has_room || pop))
        else $error("push into a full result queue");
`endif

endmodule

### rtl/core/xorshift_keystream_byte_scrambler_core.sv
// Top level of the xorshift128+ keystream byte scrambler.
// Depends on xsks_pkg, xsks_engine and xsks_emit.
`timescale 1ns / 1ps

// Usage:
// Bytes of a message arrive on the s_ stream, one byte per transfer, with s_tlast on
// the final byte. Results leave on the m_ stream, with m_tlast on the result of the
// final byte. The cfg_ port writes mode (index 0), seed_first (1) and seed_second (2);
// write it only while no message results are outstanding.
// Scramble mode: the first byte of a message produces 16 header bytes (seed_first
// then seed_second, low byte first) followed by the XORed data byte. Every later
// byte produces one XORed byte. Unscramble mode: the first 16 bytes are absorbed as
// seeds and produce nothing; later bytes are XORed with the same keystream.
// A result is registered in the result queue at its input transfer; m_ offers it from there.
// Throughput: one byte per cycle while the queue has room. The keystream word (one 64-bit
// add) is computed in the same cycle as the byte, between the generator registers and a
// two-entry result queue. A header result holds the output while the serializer walks
// the 16 seed bytes, so input stalls once the queue behind it has filled.
// Reset clears the generator, the header counter and the result queue; the next
// byte starts a new message. When the receiver stalls, the queue absorbs up to two
// results, and s_tready drops only when both entries are occupied.

module xorshift_keystream_byte_scrambler_core
    import xsks_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Configuration write port.
    input  logic        cfg_we,
    input  logic [1:0]  cfg_index,
    input  logic [63:0] cfg_wdata,
    // Input stream.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] data_byte
    input  logic        s_tlast,   // final_byte
    // Result stream.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [7:0] out_byte
    output logic        m_tlast    // out_last
);

    logic        fire;
    xsks_push_t  push;
    logic [63:0] seed_first;
    logic [63:0] seed_second;
    logic        has_room;

    // A byte is taken whenever the result queue has a free entry, even while a
    // finished result waits for the receiver.
    assign s_tready = has_room;
    assign fire     = s_tvalid && s_tready;

    // Generator state, header tracking and the per-byte keystream XOR.
    xsks_engine u_engine (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_we      (cfg_we),
        .cfg_index   (cfg_index),
        .cfg_wdata   (cfg_wdata),
        .fire        (fire),
        .in_byte     (s_tdata),
        .in_last     (s_tlast),
        .push        (push),
        .seed_first  (seed_first),
        .seed_second (seed_second)
    );

    // Result queue and header expansion. The user must not change the seeds while a
    // header is pending (not enforced by the block), so the serializer reads the config registers.
    xsks_emit u_emit (
        .clk         (clk),
        .rst_n       (rst_n),
        .push        (push),
        .seed_first  (seed_first),
        .seed_second (seed_second),
        .has_room    (has_room),
        .out_valid   (m_tvalid),
        .out_ready   (m_tready),
        .out_byte    (m_tdata),
        .out_last    (m_tlast)
    );

endmodule

### tb/xorshift_keystream_byte_scrambler_core_tb.sv
// Self-checking testbench for the xorshift128+ keystream byte scrambler core.
// Depends on xsks_pkg for the register indexes, modes and seed constants, and on the core itself.
`timescale 1ns / 1ps

import xsks_pkg::*;

typedef struct packed {
    logic [7:0] data;
    logic       last;
} out_byte_t;

class keystream_scoreboard;
    logic        mode;
    logic [63:0] seed_a;
    logic [63:0] seed_b;
    logic [63:0] gen_a;
    logic [63:0] gen_b;
    logic [63:0] key_word;
    logic [63:0] seed_gather;
    logic [3:0]  key_idx;
    logic [4:0]  hdr_cnt;
    out_byte_t   expected_bytes[$];
    int          errors;

    function new();
        mode        = MODE_SCRAMBLE;
        seed_a      = '0;
        seed_b      = '0;
        gen_a       = '0;
        gen_b       = '0;
        key_word    = '0;
        seed_gather = '0;
        key_idx     = KEY_IDX_EMPTY;
        hdr_cnt     = '0;
        errors      = 0;
    endfunction

    function void write_reg(cfg_index_t idx, logic [63:0] value);
        case (idx)
            CFG_MODE:        mode   = value[0];
            CFG_SEED_FIRST:  seed_a = value;
            CFG_SEED_SECOND: seed_b = value;
            default:         ;
        endcase
    endfunction

    // Appends one expected result at the tail of the queue.
    function void add_expected(out_byte_t item);
        expected_bytes = {expected_bytes, item};
    endfunction

    // Next keystream byte; a fresh generator word is drawn every eight bytes.
    function logic [7:0] next_key();
        logic [63:0] x;
        logic [63:0] y;
        if (key_idx >= KEY_IDX_EMPTY)
        begin
            x        = gen_a;
            y        = gen_b;
            gen_a    = y;
            x        = x ^ (x << 23);
            gen_b    = x ^ y ^ (x >> 17) ^ (y >> 26);
            key_word = gen_b + y;
            key_idx  = '0;
        end
        next_key = 8'(key_word >> (8 * key_idx));
        key_idx  = key_idx + 1'b1;
    endfunction

    function void note_byte(logic [7:0] data, logic last);
        out_byte_t item;
        int        i;
        if (mode == MODE_SCRAMBLE)
        begin
            if (hdr_cnt != HDR_LEN)
            begin
                // Message start: the raw seeds go out first, low byte first.
                for (i = 0; i < 8; i++)
                begin
                    item.data = seed_a[i*8 +: 8];
                    item.last = 1'b0;
                    add_expected(item);
                end
                for (i = 0; i < 8; i++)
                begin
                    item.data = seed_b[i*8 +: 8];
                    item.last = 1'b0;
                    add_expected(item);
                end
                gen_a   = (seed_a != 64'd0) ? seed_a : ZERO_SEED_A;
                gen_b   = (seed_b != 64'd0) ? seed_b : ZERO_SEED_B;
                key_idx = KEY_IDX_EMPTY;
                hdr_cnt = HDR_LEN;
            end
            item.data = data ^ next_key();
            item.last = last;
            add_expected(item);
        end
        else if (hdr_cnt < HDR_LEN)
        begin
            // Header gathering: bytes shift in from the top, so the first one ends lowest.
            seed_gather = {data, seed_gather[63:8]};
            hdr_cnt     = hdr_cnt + 1'b1;
            if (hdr_cnt == HDR_HALF)
            begin
                gen_a       = (seed_gather != 64'd0) ? seed_gather : ZERO_SEED_A;
                seed_gather = '0;
            end
            else if (hdr_cnt == HDR_LEN)
            begin
                gen_b       = (seed_gather != 64'd0) ? seed_gather : ZERO_SEED_B;
                seed_gather = '0;
                key_idx     = KEY_IDX_EMPTY;
            end
        end
        else
        begin
            item.data = data ^ next_key();
            item.last = last;
            add_expected(item);
        end
        if (last)
        begin
            hdr_cnt     = '0;
            seed_gather = '0;
            key_idx     = KEY_IDX_EMPTY;
        end
    endfunction

    function void check_byte(logic [7:0] data, logic last);
        out_byte_t want;
        if (expected_bytes.size() == 0)
        begin
            errors++;
            $display("%0t: unexpected result, out_byte %h out_last %b", $time, data, last);
            return;
        end
        want = expected_bytes.pop_front();
        if (want.data !== data)
        begin
            errors++;
            $display("%0t: out_byte expected %h actual %h", $time, want.data, data);
        end
        if (want.last !== last)
        begin
            errors++;
            $display("%0t: out_last expected %b actual %b", $time, want.last, last);
        end
    endfunction

    function int pending();
        return expected_bytes.size();
    endfunction
endclass

module xorshift_keystream_byte_scrambler_core_tb;

    // No new random phase starts once this many bytes have been transferred in total.
    localparam int TOTAL_ITEMS = 110;
    // Cycles allowed after the last result before a register write or the verdict.
    localparam int DRAIN_CYCLES = 8;
    // Worst case stays well below this: about 200 bytes, 17 results each, with receiver stalls.
    localparam int CYCLE_LIMIT = 1000000;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [1:0]  cfg_index = '0;
    logic [63:0] cfg_wdata = '0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;   // [7:0] data_byte
    logic        s_tlast = 1'b0; // final_byte
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;        // [7:0] out_byte
    logic        m_tlast;        // out_last

    keystream_scoreboard sb;
    int                  items_sent = 0;
    int                  cycle_count = 0;
    int                  rx_hold = 0;
    logic                rx_calm = 1'b1;
    bit                  tx_calm = 1'b1;

    xorshift_keystream_byte_scrambler_core u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast)
    );

    always #5 clk = ~clk;

    // Watchdog: a hung handshake or a lost result ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("** xorshift_keystream_byte_scrambler_core: FAILED **");
            $finish;
        end
    end

    // Receiver back-pressure. In a calm stretch the receiver is always ready; otherwise
    // it stalls now and then, mostly briefly, sometimes long enough to back up a header.
    always @(posedge clk)
    begin : rx_ready_gen
        int r;
        r = $urandom_range(0, 99);
        if (!rst_n)
        begin
            m_tready <= 1'b0;
        end
        else if (rx_calm)
        begin
            m_tready <= 1'b1;
        end
        else if (rx_hold > 0)
        begin
            rx_hold  <= rx_hold - 1;
            m_tready <= 1'b0;
        end
        else if (r < 70)
        begin
            m_tready <= 1'b1;
        end
        else
        begin
            m_tready <= 1'b0;
            rx_hold  <= (r < 96) ? $urandom_range(0, 2) : $urandom_range(15, 40);
        end
    end

    // Every result transfer is checked against the oldest expected byte. Values are
    // read right after the edge, so they are the ones the core saw at that edge.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_byte(m_tdata, m_tlast);
    end

    // Sender gap before a byte: mostly none, sometimes short, rarely a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (tx_calm || r < 65)
            return 0;
        else if (r < 94)
            return $urandom_range(1, 3);
        else
            return $urandom_range(8, 30);
    endfunction

    // Message bytes lean toward the all-zero and all-one patterns now and then.
    function automatic logic [7:0] pick_data();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 8'h00;
        else if (r == 1)
            return 8'hFF;
        else
            return 8'($urandom);
    endfunction

    // Seeds: zero (replaced by the fixed constant), all ones, a single bit, or random.
    function automatic logic [63:0] pick_seed();
        int r;
        r = $urandom_range(0, 9);
        if (r == 0)
            return 64'd0;
        else if (r == 1)
            return {64{1'b1}};
        else if (r == 2)
            return 64'd1 << $urandom_range(0, 63);
        else
            return {$urandom, $urandom};
    endfunction

    // Offers one byte and waits for its transfer. Called on a rising edge, returns on
    // the edge at which the byte was taken, with s_tvalid still high.
    task automatic send_byte(input logic [7:0] data, input logic last);
        int gap;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= data;
        s_tlast  <= last;
        do
            @(posedge clk);
        while (!s_tready);
        sb.note_byte(data, last);
        items_sent++;
    endtask

    // Stops the sender until every expected result has come out, then lets the core
    // run on for a drain period, since absorbed header bytes give no result to wait for.
    task automatic settle();
        s_tvalid <= 1'b0;
        while (sb.pending() != 0)
            @(negedge clk);
        @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    // One register write; only called while the core is idle.
    task automatic cfg_write(input cfg_index_t idx, input logic [63:0] value);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        sb.write_reg(idx, value);
        @(posedge clk);
    endtask

    task automatic cfg_write_random();
        cfg_index_t idx;
        idx = cfg_index_t'($urandom_range(0, 2));
        if (idx == CFG_MODE)
            cfg_write(idx, 64'($urandom_range(0, 1) ? MODE_UNSCRAMBLE : MODE_SCRAMBLE));
        else
            cfg_write(idx, pick_seed());
    endtask

    // A whole message of random bytes; with split > 0 the core is drained and one
    // register is rewritten before byte number split, in the middle of the message.
    task automatic send_message(input int len, input int split);
        int i;
        for (i = 0; i < len; i++)
        begin
            if (split > 0 && i == split)
            begin
                settle();
                cfg_write_random();
            end
            send_byte(pick_data(), i == len - 1);
        end
    endtask

    initial
    begin : stimulus
        int   i;
        int   n_msgs;
        int   len;
        int   split;
        int   r;
        sb = new();

        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part, with no idling on either side.
        // Zero seeds: the header carries zeros while the generator uses the constants.
        cfg_write(CFG_MODE, 64'(MODE_SCRAMBLE));
        cfg_write(CFG_SEED_FIRST, 64'd0);
        cfg_write(CFG_SEED_SECOND, 64'd0);
        send_byte(8'h00, 1'b1);
        settle();

        // All-ones seeds, nine bytes so the keystream crosses into a second word.
        cfg_write(CFG_SEED_FIRST, {64{1'b1}});
        cfg_write(CFG_SEED_SECOND, {64{1'b1}});
        for (i = 0; i < 9; i++)
            send_byte((i % 2 == 0) ? 8'hFF : 8'h00, i == 8);
        settle();

        // Unscramble mode, a message that ends inside its header gives nothing.
        cfg_write(CFG_MODE, 64'(MODE_UNSCRAMBLE));
        for (i = 0; i < 4; i++)
            send_byte(8'h5A, i == 3);
        settle();

        // Seed rewritten in the middle of a scramble message: the running message keeps
        // its keystream. Then the mode flips to unscramble in the data phase, so the
        // final byte is still XORed with the same stream.
        cfg_write(CFG_MODE, 64'(MODE_SCRAMBLE));
        cfg_write(CFG_SEED_FIRST, 64'h0123_4567_89AB_CDEF);
        cfg_write(CFG_SEED_SECOND, 64'h8000_0000_0000_0001);
        send_byte(8'h11, 1'b0);
        send_byte(8'h80, 1'b0);
        settle();
        cfg_write(CFG_SEED_FIRST, 64'hFEDC_BA98_7654_3210);
        send_byte(8'h01, 1'b0);
        send_byte(8'h7F, 1'b0);
        settle();
        cfg_write(CFG_MODE, 64'(MODE_UNSCRAMBLE));
        send_byte(8'hC3, 1'b1);
        settle();

        // Mode flips to scramble while header bytes are being gathered: the next byte
        // starts a fresh message with a header from the current seeds.
        for (i = 0; i < 3; i++)
            send_byte(8'($urandom), 1'b0);
        settle();
        cfg_write(CFG_MODE, 64'(MODE_SCRAMBLE));
        send_byte(8'hA5, 1'b1);

        // Random part: phases of a new setting and a few messages each. Every phase
        // begins with the sender held back until all results are out.
        while (items_sent < TOTAL_ITEMS)
        begin
            settle();
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm <= ($urandom_range(0, 3) == 0);
            cfg_write(CFG_MODE, 64'($urandom_range(0, 1) ? MODE_UNSCRAMBLE : MODE_SCRAMBLE));
            if ($urandom_range(0, 1))
                cfg_write(CFG_SEED_FIRST, pick_seed());
            if ($urandom_range(0, 1))
                cfg_write(CFG_SEED_SECOND, pick_seed());
            n_msgs = $urandom_range(1, 3);
            for (i = 0; i < n_msgs; i++)
            begin
                r = $urandom_range(0, 9);
                if (sb.mode == MODE_SCRAMBLE)
                    len = (r == 0) ? 1 : $urandom_range(2, 20);
                else if (r == 0)
                    len = 16;
                else if (r == 1)
                    len = $urandom_range(1, 15);
                else
                    len = $urandom_range(17, 28);
                split = (len > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, len - 1) : 0;
                send_message(len, split);
            end
        end

        settle();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("** xorshift_keystream_byte_scrambler_core: PASSED **");
        else
            $display("** xorshift_keystream_byte_scrambler_core: FAILED **");
        $finish;
    end

endmodule

### xorshift_keystream_byte_scrambler_core.f
rtl/core/xsks_pkg.sv
rtl/core/xsks_engine.sv
rtl/core/xsks_emit.sv
rtl/core/xorshift_keystream_byte_scrambler_core.sv
tb/xorshift_keystream_byte_scrambler_core_tb.sv
